// ===== hdl/first_fit_heap_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_defines
// Assertion macros shared by the allocator modules.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// condition must never hold while out of reset
`define FFHA_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define FFHA_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// Types and constants of the first-fit heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package ffha_pkg;

	localparam int ADDR_W  = 22;
	localparam int SIZE_W  = 16;
	localparam int FRAME_W = 20;
	localparam int CNT_W   = 21;
	localparam int OFFS_W  = 13;
	localparam int PAGES_W = 11;
	localparam int PAGE_LIMIT = 4095;

	typedef enum logic [1:0] {
		Q_HOLD,
		Q_KEEP,
		Q_DROP,
		Q_APPEND
	} q_op_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_TOO_BIG,
		ST_NOT_FOUND,
		ST_NO_FRAMES,
		ST_TABLE_FULL,
		ST_PAGES_OUT
	} status_t;

endpackage
`default_nettype wire

// ===== hdl/first_fit_heap_allocator.sv =====
// An allocate request makes one pass over the free table.
// A free request passes over the used table, the free table and the used table again;
// if the block touched a free entry, merge passes over the free table follow until none merges.
// One request at a time; busy is high while the table passes run.
// Reset empties both tables, drops the heap page and frees all frames.
// done marks each result for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator with coalescing free table, page bump and frame claim.
// ----------------------------------------------------------------------------
`default_nettype none
`include "first_fit_heap_allocator_defines.svh"
module first_fit_heap_allocator #(
	parameter int FREE_ENTRIES = 64,
	parameter int USED_ENTRIES = 64,
	parameter int FRAME_WORDS  = 32768,
	parameter int HEAP_PAGES   = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        op,
	input  wire logic [15:0] request_size,
	input  wire logic [21:0] block_address,
	output logic             done,
	output logic [21:0]      result_address,
	output logic [2:0]       status,
	output logic             map_valid,
	output logic [9:0]       map_page,
	output logic [19:0]      map_frame,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [20:0] cfg_data
);

	localparam int AW    = ffha_pkg::ADDR_W;
	localparam int MAXE  = (FREE_ENTRIES > USED_ENTRIES) ? FREE_ENTRIES : USED_ENTRIES;
	localparam int CW    = $clog2(MAXE + 1);
	localparam int FCW   = $clog2(FREE_ENTRIES + 1);
	localparam int UCW   = $clog2(USED_ENTRIES + 1);
	localparam int FRAME_TOTAL = FRAME_WORDS * 32;

	typedef enum logic [2:0] {
		S_IDLE, S_ASCAN, S_AFIN, S_FFIND, S_FMOD, S_FDROP, S_MSCAN, S_MMERGE
	} state_t;

	state_t state_q;
	logic op_q;
	logic [15:0] size_q;
	logic [AW-1:0] addr_q, got_addr_q;
	logic [CW-1:0] j_q, pn_q, ia_q, jb_q, fk_q;
	logic hit_q, touch_q;
	logic [15:0] flen_q;
	logic [AW-1:0] lenb_q;
	logic [AW:0] end_a_q, end_next_q;
	logic [AW-1:0] page_base_q;
	logic [ffha_pkg::OFFS_W-1:0] page_off_q;
	logic [ffha_pkg::PAGES_W-1:0] pages_q;
	logic [ffha_pkg::CNT_W-1:0] nf_q;

	logic done_q, map_valid_q;
	logic [AW-1:0] res_addr_q;
	ffha_pkg::status_t status_q;
	logic [9:0] map_page_q;
	logic [19:0] map_frame_q;

	ffha_pkg::q_op_t fq_op, uq_op;
	logic [AW-1:0] fq_start, uq_start, fh_start, uh_start;
	logic [AW-1:0] fq_len, fh_len;
	logic [15:0] uq_len, uh_len;
	logic [FCW-1:0] fq_count;
	logic [UCW-1:0] uq_count;

	ffha_queue #(.DEPTH(FREE_ENTRIES), .LEN_W(AW)) u_free (
		.clk(clk), .arst_n(arst_n), .op(fq_op), .in_start(fq_start), .in_len(fq_len),
		.head_start(fh_start), .head_len(fh_len), .count(fq_count)
	);

	ffha_queue #(.DEPTH(USED_ENTRIES), .LEN_W(16)) u_used (
		.clk(clk), .arst_n(arst_n), .op(uq_op), .in_start(uq_start), .in_len(uq_len),
		.head_start(uh_start), .head_len(uh_len), .count(uq_count)
	);

	wire pass_on = (j_q != pn_q);
	wire [AW:0] fh_end = {1'b0, fh_start} + {1'b0, fh_len};
	wire [AW:0] stop = {1'b0, addr_q} + (AW+1)'(flen_q);
	wire [AW-1:0] size_ext = AW'(size_q);
	wire full_free = (fq_count == FCW'(FREE_ENTRIES));

	// allocation tail: page bump or new page
	wire need_page = ({1'b0, page_off_q} + 14'(size_q)) > 14'(ffha_pkg::PAGE_LIMIT);
	wire too_big = size_q > 16'(ffha_pkg::PAGE_LIMIT);
	wire pages_out = pages_q >= ffha_pkg::PAGES_W'(HEAP_PAGES);
	wire no_frame = nf_q >= ffha_pkg::CNT_W'(FRAME_TOTAL);
	wire [AW-1:0] new_base = {pages_q[9:0], 12'b0};

	logic a_ok, a_map;
	logic [AW-1:0] a_addr;
	ffha_pkg::status_t a_status;

	always_comb begin
		a_ok = 1'b0;
		a_map = 1'b0;
		a_addr = '0;
		a_status = ffha_pkg::ST_OK;
		if (hit_q) begin
			a_ok = 1'b1;
			a_addr = got_addr_q;
		end else if (too_big) begin
			a_status = ffha_pkg::ST_TOO_BIG;
		end else if (need_page) begin
			if (pages_out) begin
				a_status = ffha_pkg::ST_PAGES_OUT;
			end else if (no_frame) begin
				a_status = ffha_pkg::ST_NO_FRAMES;
			end else begin
				a_ok = 1'b1;
				a_map = 1'b1;
				a_addr = new_base;
			end
		end else begin
			a_ok = 1'b1;
			a_addr = page_base_q + AW'(page_off_q);
		end
	end

	always_comb begin
		fq_op = ffha_pkg::Q_HOLD;
		fq_start = fh_start;
		fq_len = fh_len;
		uq_op = ffha_pkg::Q_HOLD;
		uq_start = uh_start;
		uq_len = uh_len;
		unique case (state_q)
			S_ASCAN: if (pass_on) begin
				if (!hit_q && size_ext == fh_len) begin
					fq_op = ffha_pkg::Q_DROP;
				end else if (!hit_q && size_ext < fh_len) begin
					fq_op = ffha_pkg::Q_KEEP;
					fq_start = fh_start + size_ext;
					fq_len = fh_len - size_ext;
				end else begin
					fq_op = ffha_pkg::Q_KEEP;
				end
			end
			S_AFIN: if (a_ok) begin
				uq_op = ffha_pkg::Q_APPEND;
				uq_start = a_addr;
				uq_len = size_q;
			end
			S_FFIND: if (pass_on) uq_op = ffha_pkg::Q_KEEP;
			S_FMOD: begin
				if (pass_on) begin
					fq_op = ffha_pkg::Q_KEEP;
					if (!touch_q && {1'b0, fh_start} == stop) begin
						fq_start = addr_q;
						fq_len = fh_len + AW'(flen_q);
					end else if (!touch_q && fh_end == {1'b0, addr_q}) begin
						fq_len = fh_len + AW'(flen_q);
					end
				end else if (!touch_q && !full_free) begin
					fq_op = ffha_pkg::Q_APPEND;
					fq_start = addr_q;
					fq_len = AW'(flen_q);
				end
			end
			S_FDROP: if (pass_on) uq_op = (j_q == fk_q) ? ffha_pkg::Q_DROP : ffha_pkg::Q_KEEP;
			S_MSCAN: if (pass_on) fq_op = ffha_pkg::Q_KEEP;
			S_MMERGE: if (pass_on) begin
				if (j_q == jb_q) begin
					fq_op = ffha_pkg::Q_DROP;
				end else begin
					fq_op = ffha_pkg::Q_KEEP;
					if (j_q == ia_q) fq_len = fh_len + lenb_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
			page_base_q <= '0;
			page_off_q <= ffha_pkg::OFFS_W'(4096);
			pages_q <= '0;
			nf_q <= '0;
			hit_q <= 1'b0;
			touch_q <= 1'b0;
			op_q <= 1'b0;
			size_q <= '0;
			addr_q <= '0;
			got_addr_q <= '0;
			j_q <= '0;
			pn_q <= '0;
			ia_q <= '0;
			jb_q <= '0;
			fk_q <= '0;
			flen_q <= '0;
			lenb_q <= '0;
			end_a_q <= '0;
			end_next_q <= '0;
			res_addr_q <= '0;
			status_q <= ffha_pkg::ST_OK;
			map_valid_q <= 1'b0;
			map_page_q <= '0;
			map_frame_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready)
				nf_q <= (cfg_data > ffha_pkg::CNT_W'(FRAME_TOTAL)) ?
					ffha_pkg::CNT_W'(FRAME_TOTAL) : cfg_data;
			if (pass_on && state_q != S_IDLE) j_q <= j_q + 1'b1;
			unique case (state_q)
				S_IDLE: if (start) begin
					op_q <= op;
					size_q <= request_size;
					addr_q <= block_address;
					hit_q <= 1'b0;
					touch_q <= 1'b0;
					j_q <= '0;
					res_addr_q <= '0;
					map_valid_q <= 1'b0;
					map_page_q <= '0;
					map_frame_q <= '0;
					if (op) begin
						pn_q <= CW'(uq_count);
						state_q <= S_FFIND;
					end else if (uq_count == UCW'(USED_ENTRIES)) begin
						status_q <= ffha_pkg::ST_TABLE_FULL;
						done_q <= 1'b1;
					end else begin
						pn_q <= CW'(fq_count);
						state_q <= S_ASCAN;
					end
				end
				S_ASCAN: begin
					if (pass_on && !hit_q && size_ext <= fh_len) begin
						hit_q <= 1'b1;
						got_addr_q <= fh_start;
					end
					if (!pass_on) state_q <= S_AFIN;
				end
				S_AFIN: begin
					status_q <= a_status;
					done_q <= 1'b1;
					state_q <= S_IDLE;
					if (a_ok) res_addr_q <= a_addr;
					if (a_map) begin
						map_valid_q <= 1'b1;
						map_page_q <= pages_q[9:0];
						map_frame_q <= nf_q[19:0];
						page_base_q <= new_base;
						pages_q <= pages_q + 1'b1;
						nf_q <= nf_q + 1'b1;
						page_off_q <= ffha_pkg::OFFS_W'(size_q);
					end else if (a_ok && !hit_q) begin
						page_off_q <= page_off_q + ffha_pkg::OFFS_W'(size_q);
					end
				end
				S_FFIND: begin
					if (pass_on && !hit_q && uh_start == addr_q) begin
						hit_q <= 1'b1;
						fk_q <= j_q;
						flen_q <= uh_len;
					end
					if (!pass_on) begin
						j_q <= '0;
						if (!hit_q) begin
							status_q <= ffha_pkg::ST_NOT_FOUND;
							done_q <= 1'b1;
							state_q <= S_IDLE;
						end else if (flen_q == '0) begin
							pn_q <= CW'(uq_count);
							state_q <= S_FDROP;
						end else begin
							pn_q <= CW'(fq_count);
							state_q <= S_FMOD;
						end
					end
				end
				S_FMOD: begin
					if (pass_on && !touch_q &&
						({1'b0, fh_start} == stop || fh_end == {1'b0, addr_q}))
						touch_q <= 1'b1;
					if (!pass_on) begin
						j_q <= '0;
						pn_q <= CW'(uq_count);
						if (!touch_q && full_free) begin
							status_q <= ffha_pkg::ST_TABLE_FULL;
							done_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_FDROP;
						end
					end
				end
				S_FDROP: if (!pass_on) begin
					j_q <= '0;
					if (touch_q) begin
						// merge passes start from the first entry
						pn_q <= CW'(fq_count);
						ia_q <= '0;
						hit_q <= 1'b0;
						end_a_q <= fh_end;
						state_q <= S_MSCAN;
					end else begin
						status_q <= ffha_pkg::ST_OK;
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_MSCAN: begin
					if (pass_on && j_q != ia_q && !hit_q && {1'b0, fh_start} == end_a_q) begin
						hit_q <= 1'b1;
						jb_q <= j_q;
						lenb_q <= fh_len;
					end
					if (pass_on && j_q == CW'(ia_q + 1'b1)) end_next_q <= fh_end;
					if (!pass_on) begin
						j_q <= '0;
						if (hit_q) begin
							state_q <= S_MMERGE;
						end else if (CW'(ia_q + 1'b1) >= pn_q) begin
							status_q <= ffha_pkg::ST_OK;
							done_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							ia_q <= ia_q + 1'b1;
							end_a_q <= end_next_q;
						end
					end
				end
				S_MMERGE: if (!pass_on) begin
					j_q <= '0;
					pn_q <= CW'(fq_count);
					ia_q <= '0;
					hit_q <= 1'b0;
					end_a_q <= fh_end;
					state_q <= S_MSCAN;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign cfg_ready = !busy;
	assign done = done_q;
	assign result_address = res_addr_q;
	assign status = status_q;
	assign map_valid = map_valid_q;
	assign map_page = map_page_q;
	assign map_frame = map_frame_q;

	`FFHA_NEVER(a_done_idle, done_q && busy, "result while a request is in flight")
	`FFHA_NEVER(a_map_fail, done_q && map_valid_q && (status_q != ffha_pkg::ST_OK),
		"page mapped on a failed request")
	`FFHA_NEVER(a_free_map, done_q && op_q && map_valid_q, "free request mapped a page")

endmodule
`default_nettype wire

// ===== hdl/ffha_cell.sv =====
// ----------------------------------------------------------------------------
// ffha_cell
// One table entry: takes its neighbor's entry on a shift, new data on a load.
// ----------------------------------------------------------------------------
`default_nettype none
module ffha_cell #(
	parameter int LEN_W = 22
) (
	input  wire logic                      clk,
	input  wire logic                      shift,
	input  wire logic                      load,
	input  wire logic [ffha_pkg::ADDR_W-1:0] next_start,
	input  wire logic [LEN_W-1:0]          next_len,
	input  wire logic [ffha_pkg::ADDR_W-1:0] load_start,
	input  wire logic [LEN_W-1:0]          load_len,
	output logic      [ffha_pkg::ADDR_W-1:0] start_q,
	output logic      [LEN_W-1:0]          len_q
);

	always_ff @(posedge clk) begin
		if (load) begin
			start_q <= load_start;
			len_q   <= load_len;
		end else if (shift) begin
			start_q <= next_start;
			len_q   <= next_len;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/ffha_queue.sv =====
// ----------------------------------------------------------------------------
// ffha_queue
// Ordered table as a chain of cells; the head pops and is kept at the tail,
// dropped, or a new entry is appended behind the last one.
// ----------------------------------------------------------------------------
`default_nettype none
`include "first_fit_heap_allocator_defines.svh"
module ffha_queue #(
	parameter int DEPTH = 64,
	parameter int LEN_W = 22,
	localparam int CW   = $clog2(DEPTH + 1)
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire ffha_pkg::q_op_t             op,
	input  wire logic [ffha_pkg::ADDR_W-1:0] in_start,
	input  wire logic [LEN_W-1:0]            in_len,
	output logic      [ffha_pkg::ADDR_W-1:0] head_start,
	output logic      [LEN_W-1:0]            head_len,
	output logic      [CW-1:0]               count
);

	logic [ffha_pkg::ADDR_W-1:0] st [DEPTH];
	logic [LEN_W-1:0]            ln [DEPTH];
	logic [CW-1:0]               count_q;

	wire pop = (op == ffha_pkg::Q_KEEP) || (op == ffha_pkg::Q_DROP);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic sh, ld;
		assign sh = pop && (CW'(i + 1) < count_q);
		assign ld = ((op == ffha_pkg::Q_KEEP) && (CW'(i + 1) == count_q)) ||
			((op == ffha_pkg::Q_APPEND) && (CW'(i) == count_q));
		ffha_cell #(.LEN_W(LEN_W)) u_cell (
			.clk       (clk),
			.shift     (sh),
			.load      (ld),
			.next_start(st[(i + 1 < DEPTH) ? i + 1 : i]),
			.next_len  (ln[(i + 1 < DEPTH) ? i + 1 : i]),
			.load_start(in_start),
			.load_len  (in_len),
			.start_q   (st[i]),
			.len_q     (ln[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			unique case (op)
				ffha_pkg::Q_DROP:   count_q <= count_q - 1'b1;
				ffha_pkg::Q_APPEND: count_q <= count_q + 1'b1;
				default:            count_q <= count_q;
			endcase
		end
	end

	assign head_start = st[0];
	assign head_len   = ln[0];
	assign count      = count_q;

	`FFHA_NEVER(a_count_range, count_q > CW'(DEPTH), "queue count beyond depth")
	`FFHA_NEVER(a_drop_empty, (op == ffha_pkg::Q_DROP) && (count_q == '0), "drop on empty queue")
	`FFHA_NEVER(a_append_full, (op == ffha_pkg::Q_APPEND) && (count_q == CW'(DEPTH)),
		"append on full queue")

endmodule
`default_nettype wire

// ===== test/first_fit_heap_allocator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_tb
// Self-checking bench for the allocator. A queue of requests feeds a clocked
// driver, and an in-bench model of the free table, the allocation table, the
// heap page and the frame pool predicts every result. A clocked monitor checks
// each done strobe against the oldest prediction. The frame reservation is
// rewritten between phases while the allocator is idle.
// ----------------------------------------------------------------------------
`default_nettype none
module first_fit_heap_allocator_tb;

	localparam int FREE_N     = 64;
	localparam int USED_N     = 64;
	localparam int FRAME_N    = 32768 * 32;
	localparam int HEAP_N     = 1024;
	localparam int unsigned AMASK = 32'h003F_FFFF;
	localparam int PAGE_BYTES = 4096;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// how a free request finds its address when it is driven
	typedef enum logic [1:0] {
		PICK_NONE,
		PICK_OLDEST,
		PICK_NEWEST,
		PICK_ANY
	} pick_t;

	typedef struct {
		logic        op;
		logic [15:0] size;
		logic [21:0] addr;
		pick_t       pick;
	} heap_req_t;

	typedef struct {
		logic [21:0]       addr;
		ffha_pkg::status_t status;
		logic              mv;
		logic [9:0]        page;
		logic [19:0]       frame;
	} heap_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        op = OP_ALLOC;
	logic [15:0] request_size = '0;
	logic [21:0] block_address = '0;
	logic        cfg_valid = 1'b0;
	logic [20:0] cfg_data = '0;
	logic        busy, done, map_valid, cfg_ready;
	logic [21:0] result_address;
	logic [2:0]  status;
	logic [9:0]  map_page;
	logic [19:0] map_frame;

	first_fit_heap_allocator i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.request_size(request_size), .block_address(block_address), .done(done),
		.result_address(result_address), .status(status), .map_valid(map_valid),
		.map_page(map_page), .map_frame(map_frame), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// allocator model state
	int unsigned free_base[FREE_N], free_len[FREE_N], free_cnt = 0;
	int unsigned used_base[USED_N], used_len[USED_N], used_cnt = 0;
	int unsigned page_base = 0, page_off = PAGE_BYTES, pages_used = 0;
	// frames are claimed in order, so the lowest free one is a counter
	int unsigned next_frame = 0;

	heap_req_t    pending_q[$];
	heap_result_t expected_q[$];
	int  errors = 0;
	int  idle_left = 0;
	bit  final_phase = 0;
	bit  accepted;

	function automatic void drop_free(int k);
		for (int m = k; m + 1 < free_cnt; m++) begin
			free_base[m] = free_base[m + 1];
			free_len[m] = free_len[m + 1];
		end
		free_cnt--;
	endfunction

	function automatic void drop_used(int k);
		for (int m = k; m + 1 < used_cnt; m++) begin
			used_base[m] = used_base[m + 1];
			used_len[m] = used_len[m + 1];
		end
		used_cnt--;
	endfunction

	function automatic void coalesce_free();
		bit again;
		again = 1;
		while (again) begin
			again = 0;
			for (int a = 0; a < free_cnt && !again; a++)
				for (int b = 0; b < free_cnt && !again; b++)
					if (a != b && free_base[a] + free_len[a] == free_base[b]) begin
						free_len[a] = (free_len[a] + free_len[b]) & AMASK;
						drop_free(b);
						again = 1;
					end
		end
	endfunction

	function automatic void load_frames(int unsigned reserved);
		next_frame = (reserved > FRAME_N) ? FRAME_N : reserved;
	endfunction

	function automatic heap_result_t alloc_block(int unsigned size);
		heap_result_t r;
		int unsigned addr;
		bit got;
		r.addr = '0; r.status = ffha_pkg::ST_OK; r.mv = 0; r.page = '0; r.frame = '0;
		addr = 0;
		got = 0;
		if (used_cnt >= USED_N) begin
			r.status = ffha_pkg::ST_TABLE_FULL;
			return r;
		end
		for (int k = 0; k < free_cnt; k++) begin
			if (size == free_len[k]) begin
				addr = free_base[k];
				drop_free(k);
				got = 1;
				break;
			end
			if (size < free_len[k]) begin
				addr = free_base[k];
				free_len[k] -= size;
				free_base[k] = (free_base[k] + size) & AMASK;
				got = 1;
				break;
			end
		end
		if (!got) begin
			if (size > ffha_pkg::PAGE_LIMIT) begin
				r.status = ffha_pkg::ST_TOO_BIG;
				return r;
			end
			if (page_off + size > ffha_pkg::PAGE_LIMIT) begin
				if (pages_used >= HEAP_N) begin
					r.status = ffha_pkg::ST_PAGES_OUT;
					return r;
				end
				if (next_frame >= FRAME_N) begin
					r.status = ffha_pkg::ST_NO_FRAMES;
					return r;
				end
				page_base = (pages_used * PAGE_BYTES) & AMASK;
				r.mv = 1;
				r.page = pages_used[9:0];
				r.frame = next_frame[19:0];
				next_frame++;
				pages_used++;
				page_off = 0;
			end
			addr = (page_base + page_off) & AMASK;
			page_off += size;
		end
		used_base[used_cnt] = addr;
		used_len[used_cnt] = size & 16'hFFFF;
		used_cnt++;
		r.addr = addr[21:0];
		return r;
	endfunction

	function automatic heap_result_t release_block(int unsigned addr);
		heap_result_t r;
		int k;
		int unsigned len, stop;
		r.addr = '0; r.status = ffha_pkg::ST_OK; r.mv = 0; r.page = '0; r.frame = '0;
		k = -1;
		for (int i = 0; i < used_cnt; i++)
			if (used_base[i] == addr) begin
				k = i;
				break;
			end
		if (k < 0) begin
			r.status = ffha_pkg::ST_NOT_FOUND;
			return r;
		end
		len = used_len[k];
		if (len == 0) begin
			drop_used(k);
			return r;
		end
		stop = addr + len;
		for (int m = 0; m < free_cnt; m++) begin
			if (free_base[m] == stop) begin
				free_base[m] = addr;
				free_len[m] = (free_len[m] + len) & AMASK;
				drop_used(k);
				coalesce_free();
				return r;
			end
			if (free_base[m] + free_len[m] == addr) begin
				free_len[m] = (free_len[m] + len) & AMASK;
				drop_used(k);
				coalesce_free();
				return r;
			end
		end
		if (free_cnt >= FREE_N) begin
			r.status = ffha_pkg::ST_TABLE_FULL;
			return r;
		end
		free_base[free_cnt] = addr;
		free_len[free_cnt] = len;
		free_cnt++;
		drop_used(k);
		return r;
	endfunction

	function automatic logic [21:0] resolve_addr(heap_req_t q);
		if (q.pick == PICK_NONE || used_cnt == 0)
			return q.addr;
		case (q.pick)
			PICK_OLDEST: return used_base[0][21:0];
			PICK_NEWEST: return used_base[used_cnt - 1][21:0];
			default:     return used_base[$urandom_range(0, used_cnt - 1)][21:0];
		endcase
	endfunction

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			accepted = start && !busy;
			if (accepted) begin
				expected_q.push_back(op == OP_ALLOC ? alloc_block(request_size)
					: release_block(block_address));
				void'(pending_q.pop_front());
			end
			if (start && !accepted) begin
				// hold the request until it is taken
			end else if (idle_left > 0) begin
				idle_left--;
				start <= 1'b0;
			end else if (pending_q.size() > 0) begin
				if ((!final_phase || pending_q.size() > 120) && $urandom_range(0, 5) == 0) begin
					idle_left = $urandom_range(0, 2);
					start <= 1'b0;
				end else begin
					start <= 1'b1;
					op <= pending_q[0].op;
					request_size <= pending_q[0].size;
					block_address <= resolve_addr(pending_q[0]);
				end
			end else
				start <= 1'b0;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: addr=%h status=%0d", result_address, status);
			end else begin
				heap_result_t e;
				e = expected_q.pop_front();
				if (result_address !== e.addr || status !== e.status || map_valid !== e.mv
					|| map_page !== e.page || map_frame !== e.frame) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp %h/%0d map %b/%0d/%0d got %h/%0d map %b/%0d/%0d",
							e.addr, e.status, e.mv, e.page, e.frame, result_address, status,
							map_valid, map_page, map_frame);
				end
			end
		end
	end

	task automatic push_req(logic o, int unsigned size, int unsigned addr, pick_t p);
		heap_req_t q;
		q.op = o;
		q.size = size[15:0];
		q.addr = addr[21:0];
		q.pick = p;
		pending_q.push_back(q);
	endtask

	task automatic wait_idle();
		while (pending_q.size() != 0 || expected_q.size() != 0 || start || busy)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reserved(int unsigned v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v[20:0];
		do @(posedge clk); while (!cfg_ready);
		load_frames(v & 32'h1F_FFFF);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_size_alloc();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)      push_req(OP_ALLOC, $urandom_range(0, 64), 0, PICK_NONE);
		else if (r < 80) push_req(OP_ALLOC, $urandom_range(0, 1024), 0, PICK_NONE);
		else if (r < 93) push_req(OP_ALLOC, $urandom_range(0, 4095), 0, PICK_NONE);
		else             push_req(OP_ALLOC, $urandom & 16'hFFFF, 0, PICK_NONE);
	endtask

	initial begin
		int r, n;
		load_frames(0);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero size, page mapping, too big, unknown address, reuse
		push_req(OP_ALLOC, 0, 0, PICK_NONE);
		push_req(OP_FREE, 0, 0, PICK_NEWEST);
		push_req(OP_ALLOC, 1, 0, PICK_NONE);
		push_req(OP_ALLOC, 4095, 0, PICK_NONE);
		push_req(OP_ALLOC, 4096, 0, PICK_NONE);
		push_req(OP_ALLOC, 65535, 0, PICK_NONE);
		push_req(OP_ALLOC, 100, 0, PICK_NONE);
		push_req(OP_FREE, 0, 22'h3FFFFF, PICK_NONE);
		push_req(OP_FREE, 16'hFFFF, 0, PICK_NEWEST);
		push_req(OP_ALLOC, 100, 0, PICK_NONE);
		push_req(OP_ALLOC, 50, 0, PICK_NONE);
		push_req(OP_FREE, 0, 0, PICK_OLDEST);
		push_req(OP_ALLOC, 0, 0, PICK_NONE);
		push_req(OP_FREE, 0, 0, PICK_ANY);
		push_req(OP_FREE, 0, 0, PICK_ANY);
		push_req(OP_ALLOC, 4000, 0, PICK_NONE);
		push_req(OP_FREE, 0, 0, PICK_NEWEST);
		push_req(OP_ALLOC, 10, 0, PICK_NONE);
		push_req(OP_ALLOC, 10, 0, PICK_NONE);
		push_req(OP_FREE, 0, 0, PICK_OLDEST);
		push_req(OP_FREE, 0, 0, PICK_NEWEST);
		wait_idle();

		// frame pool exhaustion at the top end, then clamped and full
		write_reserved(1048575);
		repeat (3) push_req(OP_ALLOC, 4095, 0, PICK_NONE);
		wait_idle();
		write_reserved(21'h1FFFFF);
		repeat (2) push_req(OP_ALLOC, 4095, 0, PICK_NONE);
		wait_idle();
		write_reserved(1048576);
		push_req(OP_ALLOC, 4095, 0, PICK_NONE);
		wait_idle();
		write_reserved($urandom_range(0, 2000));
		wait_idle();
		write_reserved(0);

		// empty and refill the allocation table, then fragment the free table until full
		n = used_cnt;
		repeat (n) push_req(OP_FREE, 0, 0, PICK_ANY);
		wait_idle();
		repeat (USED_N + 1) push_req(OP_ALLOC, 4095, 0, PICK_NONE);
		wait_idle();
		repeat (USED_N) push_req(OP_FREE, 0, 0, PICK_ANY);
		push_req(OP_ALLOC, 10, 0, PICK_NONE);
		push_req(OP_ALLOC, 10, 0, PICK_NONE);
		push_req(OP_FREE, 0, 0, PICK_OLDEST);
		wait_idle();
		write_reserved($urandom_range(0, 1048576));

		// random traffic, allocations mixed with frees of live blocks and of random addresses
		final_phase = 1;
		for (int i = 0; i < 750; i++) begin
			r = $urandom_range(0, 99);
			if (r < 48)      random_size_alloc();
			else if (r < 90) push_req(OP_FREE, $urandom & 16'hFFFF, 0, PICK_ANY);
			else             push_req(OP_FREE, $urandom & 16'hFFFF, $urandom & AMASK,
				PICK_NONE);
		end
		wait_idle();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#2000000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
`default_nettype wire

// ===== first_fit_heap_allocator.f =====
+incdir+hdl
hdl/ffha_pkg.sv
hdl/ffha_cell.sv
hdl/ffha_queue.sv
hdl/first_fit_heap_allocator.sv
test/first_fit_heap_allocator_tb.sv
